### rtl/rv64im_integer_execute_unit_macros.svh
// Assertion macros shared by the checker of the integer execute unit.
// Depends on nothing; included by files that hold assertions.
`ifndef RV64IM_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RV64IM_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define RIEI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("execute unit check failed");

// Next-cycle implication, switched off while reset is held.
`define RIEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("execute unit check failed");

// Next-cycle implication that is checked through reset as well.
`define RIEI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("execute unit check failed");

`endif

### rtl/riei_pkg.sv
// Types, operation codes and helpers of the RV64IM integer execute unit.
// Depends on nothing; used by every module of the unit.
package riei_pkg;

    localparam int unsigned XLEN       = 64;
    localparam int unsigned DIV_STAGES = XLEN;
    localparam int unsigned MUL_STAGES = 2;

    typedef enum logic [5:0] {
        CMD_ADD    = 6'd0,
        CMD_SUB    = 6'd1,
        CMD_SLL    = 6'd2,
        CMD_SLT    = 6'd3,
        CMD_SLTU   = 6'd4,
        CMD_XOR    = 6'd5,
        CMD_SRL    = 6'd6,
        CMD_SRA    = 6'd7,
        CMD_OR     = 6'd8,
        CMD_AND    = 6'd9,
        CMD_ADDW   = 6'd10,
        CMD_SUBW   = 6'd11,
        CMD_SLLW   = 6'd12,
        CMD_SRLW   = 6'd13,
        CMD_SRAW   = 6'd14,
        CMD_MUL    = 6'd15,
        CMD_MULH   = 6'd16,
        CMD_MULHSU = 6'd17,
        CMD_MULHU  = 6'd18,
        CMD_DIV    = 6'd19,
        CMD_DIVU   = 6'd20,
        CMD_REM    = 6'd21,
        CMD_REMU   = 6'd22,
        CMD_MULW   = 6'd23,
        CMD_DIVW   = 6'd24,
        CMD_DIVUW  = 6'd25,
        CMD_REMW   = 6'd26,
        CMD_REMUW  = 6'd27,
        CMD_BEQ    = 6'd28,
        CMD_BNE    = 6'd29,
        CMD_BLT    = 6'd30,
        CMD_BGE    = 6'd31,
        CMD_BLTU   = 6'd32,
        CMD_BGEU   = 6'd33
    } t_cmd;

    typedef struct packed {
        logic [5:0]      command;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            branch_taken;
    } t_out_item;

    typedef struct packed {
        logic neg_q;
        logic neg_r;
        logic want_rem;
        logic word;
    } t_div_ctl;

    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
        return {{(XLEN-32){v[31]}}, v[31:0]};
    endfunction

    function automatic logic is_mul(input t_cmd c);
        return (c == CMD_MUL) || (c == CMD_MULH) || (c == CMD_MULHSU) ||
               (c == CMD_MULHU) || (c == CMD_MULW);
    endfunction

    function automatic logic is_div(input t_cmd c);
        return (c == CMD_DIV) || (c == CMD_DIVU) || (c == CMD_REM) || (c == CMD_REMU) ||
               (c == CMD_DIVW) || (c == CMD_DIVUW) || (c == CMD_REMW) || (c == CMD_REMUW);
    endfunction

endpackage

### rtl/rv64im_integer_execute_unit.sv
// Top level of the RV64IM integer execute unit: input stage, result line and output register.
// Depends on riei_pkg, riei_alu, riei_mul and riei_div.
//
//   Channel   Handshake           Payload
//   input     i_valid / o_ready   i_item (command, operand_a, operand_b)
//   output    o_valid / i_ready   o_item (result, branch_taken)
//
// One item is accepted per cycle unless the output stalls; its result passes the result
// line, as deep as the divider with its one quotient bit per stage, and the output register.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module rv64im_integer_execute_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  riei_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output riei_pkg::t_out_item o_item
);

    localparam int unsigned N = riei_pkg::DIV_STAGES;
    localparam int unsigned M = riei_pkg::MUL_STAGES;

    logic                r_a_valid;
    riei_pkg::t_in_item  r_a_item;
    logic                r_side_valid [N];
    logic                r_side_div   [N];
    logic                r_side_mul   [N];
    riei_pkg::t_out_item r_side_item  [N];
    logic                r_out_valid;
    riei_pkg::t_out_item r_out_item;

    logic                s_adv;
    riei_pkg::t_out_item s_alu;
    logic [63:0]         s_mul;
    logic [63:0]         s_div;
    riei_pkg::t_out_item n_out_item;

    assign s_adv   = !r_out_valid || i_ready;
    assign o_ready = s_adv;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_a_item <= i_item;
        end
    end

    riei_alu u_alu (
        .i_item (r_a_item),
        .o_item (s_alu)
    );

    riei_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (s_adv),
        .i_item   (r_a_item),
        .o_result (s_mul)
    );

    riei_div u_div (
        .i_clk    (i_clk),
        .i_en     (s_adv),
        .i_item   (r_a_item),
        .o_result (s_div)
    );

    for (genvar k = 0; k < N; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side_valid[k] <= 1'b0;
            end else if (s_adv) begin
                r_side_valid[k] <= (k == 0) ? r_a_valid : r_side_valid[(k == 0) ? 0 : k-1];
            end
        end

        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (s_adv) begin
                    r_side_div[k]  <= riei_pkg::is_div(riei_pkg::t_cmd'(r_a_item.command));
                    r_side_mul[k]  <= riei_pkg::is_mul(riei_pkg::t_cmd'(r_a_item.command));
                    r_side_item[k] <= s_alu;
                end
            end
        end else if (k == M) begin : g_merge
            always_ff @(posedge i_clk) begin
                if (s_adv) begin
                    r_side_div[k]  <= r_side_div[k-1];
                    r_side_mul[k]  <= r_side_mul[k-1];
                    r_side_item[k] <= r_side_mul[k-1]
                        ? riei_pkg::t_out_item'{result: s_mul, branch_taken: 1'b0}
                        : r_side_item[k-1];
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (s_adv) begin
                    r_side_div[k]  <= r_side_div[k-1];
                    r_side_mul[k]  <= r_side_mul[k-1];
                    r_side_item[k] <= r_side_item[k-1];
                end
            end
        end
    end

    always_comb begin
        n_out_item = r_side_item[N-1];
        if (r_side_div[N-1]) begin
            n_out_item.result       = s_div;
            n_out_item.branch_taken = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= r_side_valid[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

### rtl/riei_alu.sv
// Combinational logic for add, shift, compare, logic, word and branch operations.
// Depends on riei_pkg.
module riei_alu (
    input  riei_pkg::t_in_item  i_item,
    output riei_pkg::t_out_item o_item
);

    always_comb begin
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
        logic [4:0]  shw;
        logic [63:0] sum;
        logic [63:0] dif;
        logic [31:0] sraw;
        logic        lts;
        logic        ltu;
        a      = i_item.operand_a;
        b      = i_item.operand_b;
        sh     = b[5:0];
        shw    = b[4:0];
        sum    = a + b;
        dif    = a - b;
        sraw   = 32'($signed(a[31:0]) >>> shw);
        lts    = $signed(a) < $signed(b);
        ltu    = a < b;
        o_item = '0;
        case (riei_pkg::t_cmd'(i_item.command))
            riei_pkg::CMD_ADD:  o_item.result = sum;
            riei_pkg::CMD_SUB:  o_item.result = dif;
            riei_pkg::CMD_SLL:  o_item.result = a << sh;
            riei_pkg::CMD_SLT:  o_item.result = {63'd0, lts};
            riei_pkg::CMD_SLTU: o_item.result = {63'd0, ltu};
            riei_pkg::CMD_XOR:  o_item.result = a ^ b;
            riei_pkg::CMD_SRL:  o_item.result = a >> sh;
            riei_pkg::CMD_SRA:  o_item.result = 64'($signed(a) >>> sh);
            riei_pkg::CMD_OR:   o_item.result = a | b;
            riei_pkg::CMD_AND:  o_item.result = a & b;
            riei_pkg::CMD_ADDW: o_item.result = riei_pkg::sext32(sum);
            riei_pkg::CMD_SUBW: o_item.result = riei_pkg::sext32(dif);
            riei_pkg::CMD_SLLW: o_item.result = riei_pkg::sext32({32'd0, a[31:0] << shw});
            riei_pkg::CMD_SRLW: o_item.result = riei_pkg::sext32({32'd0, a[31:0] >> shw});
            riei_pkg::CMD_SRAW: o_item.result = riei_pkg::sext32({32'd0, sraw});
            riei_pkg::CMD_BEQ:  o_item.branch_taken = (a == b);
            riei_pkg::CMD_BNE:  o_item.branch_taken = (a != b);
            riei_pkg::CMD_BLT:  o_item.branch_taken = lts;
            riei_pkg::CMD_BGE:  o_item.branch_taken = !lts;
            riei_pkg::CMD_BLTU: o_item.branch_taken = ltu;
            riei_pkg::CMD_BGEU: o_item.branch_taken = !ltu;
            default:            o_item = '0;
        endcase
    end

endmodule

### rtl/riei_mul.sv
// Two-stage 64 by 64 multiplier: partial products of 32-bit halves, then their sum and sign fix.
// Depends on riei_pkg.
module riei_mul (
    input  logic                i_clk,
    input  logic                i_en,
    input  riei_pkg::t_in_item  i_item,
    output logic [63:0]         o_result
);

    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_p_a, r_p_b;
    logic [5:0]  r_p_cmd;
    logic [127:0] r_full;
    logic [63:0] r_s_a, r_s_b;
    logic [5:0]  r_s_cmd;
    logic [127:0] n_full;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= 64'(i_item.operand_a[31:0] * i_item.operand_b[31:0]);
            r_lh    <= 64'(i_item.operand_a[31:0] * i_item.operand_b[63:32]);
            r_hl    <= 64'(i_item.operand_a[63:32] * i_item.operand_b[31:0]);
            r_hh    <= 64'(i_item.operand_a[63:32] * i_item.operand_b[63:32]);
            r_p_a   <= i_item.operand_a;
            r_p_b   <= i_item.operand_b;
            r_p_cmd <= i_item.command;
        end
    end

    assign n_full = {r_hh, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_full  <= n_full;
            r_s_a   <= r_p_a;
            r_s_b   <= r_p_b;
            r_s_cmd <= r_p_cmd;
        end
    end

    always_comb begin
        logic [63:0] hi;
        logic [63:0] cor_a;
        logic [63:0] cor_b;
        hi    = r_full[127:64];
        cor_a = r_s_a[63] ? r_s_b : 64'd0;
        cor_b = r_s_b[63] ? r_s_a : 64'd0;
        case (riei_pkg::t_cmd'(r_s_cmd))
            riei_pkg::CMD_MUL:    o_result = r_full[63:0];
            riei_pkg::CMD_MULH:   o_result = hi - cor_a - cor_b;
            riei_pkg::CMD_MULHSU: o_result = hi - cor_a;
            riei_pkg::CMD_MULHU:  o_result = hi;
            riei_pkg::CMD_MULW:   o_result = riei_pkg::sext32(r_full[63:0]);
            default:              o_result = '0;
        endcase
    end

endmodule

### rtl/riei_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sign handling.
// Depends on riei_pkg.
module riei_div (
    input  logic                i_clk,
    input  logic                i_en,
    input  riei_pkg::t_in_item  i_item,
    output logic [63:0]         o_result
);

    localparam int unsigned N = riei_pkg::DIV_STAGES;

    logic [63:0]        r_rem [N];
    logic [63:0]        r_quo [N];
    logic [63:0]        r_dsr [N];
    riei_pkg::t_div_ctl r_ctl [N];

    logic [63:0]        s_mag_a;
    logic [63:0]        s_mag_b;
    riei_pkg::t_div_ctl s_ctl;

    always_comb begin
        riei_pkg::t_cmd c;
        logic           sgn;
        logic [63:0]    a_ext;
        logic [63:0]    b_ext;
        c     = riei_pkg::t_cmd'(i_item.command);
        sgn   = (c == riei_pkg::CMD_DIV) || (c == riei_pkg::CMD_REM) ||
                (c == riei_pkg::CMD_DIVW) || (c == riei_pkg::CMD_REMW);
        s_ctl.word     = (c == riei_pkg::CMD_DIVW) || (c == riei_pkg::CMD_DIVUW) ||
                         (c == riei_pkg::CMD_REMW) || (c == riei_pkg::CMD_REMUW);
        s_ctl.want_rem = (c == riei_pkg::CMD_REM) || (c == riei_pkg::CMD_REMU) ||
                         (c == riei_pkg::CMD_REMW) || (c == riei_pkg::CMD_REMUW);
        a_ext = i_item.operand_a;
        b_ext = i_item.operand_b;
        if (s_ctl.word) begin
            a_ext = sgn ? riei_pkg::sext32(i_item.operand_a) : {32'd0, i_item.operand_a[31:0]};
            b_ext = sgn ? riei_pkg::sext32(i_item.operand_b) : {32'd0, i_item.operand_b[31:0]};
        end
        s_mag_a     = (sgn && a_ext[63]) ? (64'd0 - a_ext) : a_ext;
        s_mag_b     = (sgn && b_ext[63]) ? (64'd0 - b_ext) : b_ext;
        s_ctl.neg_q = sgn && (a_ext[63] ^ b_ext[63]) && (b_ext != 64'd0);
        s_ctl.neg_r = sgn && a_ext[63];
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [63:0]        n_rem;
        logic [63:0]        n_quo;
        logic [63:0]        src_rem;
        logic [63:0]        src_quo;
        logic [63:0]        src_dsr;
        riei_pkg::t_div_ctl src_ctl;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_quo = s_mag_a;
            assign src_dsr = s_mag_b;
            assign src_ctl = s_ctl;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_quo = r_quo[k-1];
            assign src_dsr = r_dsr[k-1];
            assign src_ctl = r_ctl[k-1];
        end

        always_comb begin
            logic [64:0] shifted;
            logic [64:0] diff;
            shifted = {src_rem, src_quo[63]};
            diff    = shifted - {1'b0, src_dsr};
            if (!diff[64]) begin
                n_rem = diff[63:0];
            end else begin
                n_rem = shifted[63:0];
            end
            n_quo = {src_quo[62:0], !diff[64]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_dsr[k] <= src_dsr;
                r_ctl[k] <= src_ctl;
            end
        end
    end

    always_comb begin
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] v;
        q = r_ctl[N-1].neg_q ? (64'd0 - r_quo[N-1]) : r_quo[N-1];
        r = r_ctl[N-1].neg_r ? (64'd0 - r_rem[N-1]) : r_rem[N-1];
        v = r_ctl[N-1].want_rem ? r : q;
        o_result = r_ctl[N-1].word ? riei_pkg::sext32(v) : v;
    end

endmodule

### rtl/riei_checker.sv
// Port-level checks of the RV64IM integer execute unit, bound to its top level.
// Depends on riei_pkg and rv64im_integer_execute_unit_macros.svh.
`include "rv64im_integer_execute_unit_macros.svh"

module riei_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input riei_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_ready,
    input riei_pkg::t_out_item o_item
);

    `RIEI_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !o_valid)
    `RIEI_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_item))
    `RIEI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item))
    `RIEI_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_valid || i_ready, o_ready)
    `RIEI_ASSERT_IMPLY(a_branch_no_value, i_clk, i_rst_n, o_valid && o_item.branch_taken, o_item.result == 64'd0)

endmodule

bind rv64im_integer_execute_unit riei_checker u_riei_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
